>>> rtl/slt_pkg.sv
// types, codes and character helpers shared by the tokenizer
package slt_pkg;

	localparam int TOKEN_BUFFER_BYTES_DEF = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int KW_COUNT = 9;

	localparam logic [15:0] SAT16 = 16'hFFFF;

	localparam logic [4:0] CLS_END      = 5'd0;
	localparam logic [4:0] CLS_CHAR     = 5'd1;
	localparam logic [4:0] CLS_NUMBER   = 5'd2;
	localparam logic [4:0] CLS_IDENT    = 5'd3;
	localparam logic [4:0] CLS_KEYWORD0 = 5'd4;
	localparam logic [4:0] CLS_EQ       = 5'd13;
	localparam logic [4:0] CLS_LE       = 5'd14;
	localparam logic [4:0] CLS_GE       = 5'd15;
	localparam logic [4:0] CLS_NE       = 5'd16;
	localparam logic [4:0] CLS_AND      = 5'd17;
	localparam logic [4:0] CLS_OR       = 5'd18;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_BAR   = 8'h7C;

	// keyword text, first character in the low byte
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		64'h0000_0000_0000_6669,
		64'h0000_0000_6573_6C65,
		64'h0000_0065_6C69_6877,
		64'h0000_0074_6E69_7270,
		64'h0000_0000_6E61_6373,
		64'h0000_0000_0074_6E69,
		64'h0000_6E72_7574_6572,
		64'h0000_006B_6165_7262,
		64'h6575_6E69_746E_6F63
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd2, 4'd4, 4'd5, 4'd5, 4'd4, 4'd3, 4'd6, 4'd5, 4'd8
	};

	typedef enum logic [5:0] {
		MODE_IDLE    = 6'b000001,
		MODE_SLASH   = 6'b000010,
		MODE_COMMENT = 6'b000100,
		MODE_OP      = 6'b001000,
		MODE_NUMBER  = 6'b010000,
		MODE_IDENT   = 6'b100000
	} mode_t;

	typedef struct packed {
		logic [4:0]  token_class;
		logic [63:0] text_first_bytes;
		logic [63:0] text_next_bytes;
		logic [3:0]  text_length;
		logic [15:0] start_row;
		logic [15:0] start_column;
		logic        last_of_step;
	} tok_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A))
			|| (b == 8'h5F);
	endfunction

	function automatic logic is_op(input logic [7:0] b);
		return (b == CH_EQ) || (b == CH_LT) || (b == CH_GT) || (b == CH_BANG)
			|| (b == CH_AMP) || (b == CH_BAR);
	endfunction

	// CLS_END when the two bytes do not form an operator
	function automatic logic [4:0] pair_class(input logic [7:0] first, input logic [7:0] b);
		logic [4:0] cls;
		cls = CLS_END;
		if (b == CH_EQ) begin
			if (first == CH_EQ) cls = CLS_EQ;
			else if (first == CH_LT) cls = CLS_LE;
			else if (first == CH_GT) cls = CLS_GE;
			else if (first == CH_BANG) cls = CLS_NE;
		end
		if ((first == CH_AMP) && (b == CH_AMP)) cls = CLS_AND;
		if ((first == CH_BAR) && (b == CH_BAR)) cls = CLS_OR;
		return cls;
	endfunction

	// text beyond len is zero, so a full compare of the low word is enough
	function automatic logic [4:0] word_class(input logic [63:0] lo, input logic [3:0] len);
		logic [4:0] cls;
		cls = CLS_IDENT;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if ((len == KW_LEN[k]) && (lo == KW_TEXT[k])) cls = 5'(CLS_KEYWORD0 + 5'(k));
		end
		return cls;
	endfunction

	function automatic tok_t make_tok(input logic [4:0] cls, input logic [63:0] lo,
		input logic [63:0] hi, input logic [3:0] len, input logic [15:0] row,
		input logic [15:0] col);
		tok_t t;
		t.token_class = cls;
		t.text_first_bytes = lo;
		t.text_next_bytes = hi;
		t.text_length = len;
		t.start_row = row;
		t.start_column = col;
		t.last_of_step = 1'b0;
		return t;
	endfunction

endpackage

>>> rtl/slt_if.sv
// stream interfaces for source bytes and tokens
interface slt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_input;

	modport source (output valid, output text_byte, output end_of_input, input ready);
	modport sink (input valid, input text_byte, input end_of_input, output ready);
endinterface

interface slt_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_class;
	logic [63:0] text_first_bytes;
	logic [63:0] text_next_bytes;
	logic [3:0]  text_length;
	logic [15:0] start_row;
	logic [15:0] start_column;
	logic        last_of_step;

	modport source (output valid, output token_class, output text_first_bytes,
		output text_next_bytes, output text_length, output start_row,
		output start_column, output last_of_step, input ready);
	modport sink (input valid, input token_class, input text_first_bytes,
		input text_next_bytes, input text_length, input start_row,
		input start_column, input last_of_step, output ready);
endinterface

>>> rtl/small_language_tokenizer_unit.sv
// streaming tokenizer: source bytes in, tokens with text and position out
//
//  channel  dir  transaction
//  text     in   one source byte or an end marker
//  tokens   out  one token; up to two per input transaction
//
// one input transaction per cycle unless the scan stage stalls; the byte is
// registered, then scanned combinationally against the scan state and its
// tokens written to a 4-entry queue. the scan stage advances while the queue
// holds at most two tokens, so the token port sets the rate: one token per cycle
// while tokens.ready is high. no clearing pass: text.ready is high out of reset.
module small_language_tokenizer_unit
	import slt_pkg::*;
#(
	parameter int TOKEN_BUFFER_BYTES = TOKEN_BUFFER_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	slt_in_if.sink          text,
	slt_out_if.source       tokens
);

	localparam int IDX_W = $clog2(TOKEN_BUFFER_BYTES);
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [3:0] SPLIT_LEN = 4'(TOKEN_BUFFER_BYTES - 1);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       adv;

	// scan state
	mode_t       mode_q;
	logic [7:0]  pend_q;
	logic [7:0]  buf_q [TOKEN_BUFFER_BYTES];
	logic [3:0]  len_q;
	logic [15:0] row_q;
	logic [15:0] col_q;
	logic [15:0] trow_q;
	logic [15:0] tcol_q;

	mode_t       mode_d;
	logic [7:0]  pend_d;
	logic [3:0]  len_d;
	logic [15:0] row_d;
	logic [15:0] col_d;
	logic [15:0] trow_d;
	logic [15:0] tcol_d;
	logic            buf_we;
	logic [IDX_W-1:0] buf_widx;

	// token queue
	tok_t             fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	logic more;
	logic append;
	logic split;
	logic [3:0]  wlen;
	logic [7:0]  wbuf [TOKEN_BUFFER_BYTES];
	logic [63:0] word_lo;
	logic [63:0] word_hi;
	logic [4:0]  wcls;
	logic [4:0]  pcls;
	tok_t item_a;
	tok_t item_b;
	logic va;
	logic vb;
	logic pop;

	assign adv = valid_s1 && (cnt_q <= CNT_W'(FIFO_DEPTH - 2));
	assign text.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.text_byte;
			end_s1 <= text.end_of_input;
		end
	end

	// word being extended or flushed, with the incoming byte merged in
	assign more = (mode_q == MODE_NUMBER) ? is_digit(byte_s1)
		: (is_alpha(byte_s1) || is_digit(byte_s1));
	assign append = !end_s1 && ((mode_q == MODE_NUMBER) || (mode_q == MODE_IDENT)) && more;
	assign wlen = append ? 4'(len_q + 4'd1) : len_q;
	assign split = append && (wlen >= SPLIT_LEN);

	always_comb begin
		for (int i = 0; i < TOKEN_BUFFER_BYTES; i++) begin
			wbuf[i] = (append && (IDX_W'(i) == len_q[IDX_W-1:0])) ? byte_s1 : buf_q[i];
		end
	end

	always_comb begin
		word_lo = '0;
		word_hi = '0;
		for (int j = 0; j < 15; j++) begin
			if ((j < TOKEN_BUFFER_BYTES) && (4'(j) < wlen)) begin
				if (j < 8) word_lo[8*j +: 8] = wbuf[j];
				else word_hi[8*(j-8) +: 8] = wbuf[j];
			end
		end
	end

	assign wcls = (mode_q == MODE_NUMBER) ? CLS_NUMBER : word_class(word_lo, wlen);
	assign pcls = pair_class(pend_q, byte_s1);

	always_comb begin
		logic [15:0] row_n;
		logic [15:0] col_n;
		logic        do_start;
		row_n = row_q;
		col_n = col_q;
		if (byte_s1 == CH_LF) begin
			if (row_q != SAT16) row_n = 16'(row_q + 16'd1);
			col_n = '0;
		end else if (col_q != SAT16) begin
			col_n = 16'(col_q + 16'd1);
		end
		do_start = 1'b0;
		mode_d = mode_q;
		pend_d = pend_q;
		len_d = len_q;
		row_d = row_q;
		col_d = col_q;
		trow_d = trow_q;
		tcol_d = tcol_q;
		buf_we = 1'b0;
		buf_widx = len_q[IDX_W-1:0];
		va = 1'b0;
		vb = 1'b0;
		item_a = make_tok(CLS_CHAR, {56'd0, CH_SLASH}, '0, 4'd1, trow_q, tcol_q);
		item_b = make_tok(CLS_END, '0, '0, 4'd0, row_q, col_q);

		if (end_s1) begin
			case (mode_q)
				MODE_SLASH: begin
					va = 1'b1;
				end
				MODE_OP: begin
					va = 1'b1;
					item_a = make_tok(CLS_CHAR, {56'd0, pend_q}, '0, 4'd1, trow_q, tcol_q);
				end
				MODE_NUMBER, MODE_IDENT: begin
					va = 1'b1;
					item_a = make_tok(wcls, word_lo, word_hi, wlen, trow_q, tcol_q);
				end
				default: begin
					va = 1'b0;
				end
			endcase
			vb = 1'b1;
			mode_d = MODE_IDLE;
			pend_d = '0;
			len_d = '0;
			row_d = 16'd1;
			col_d = '0;
			trow_d = 16'd1;
			tcol_d = '0;
		end else begin
			row_d = row_n;
			col_d = col_n;
			case (mode_q)
				MODE_SLASH: begin
					if (byte_s1 == CH_SLASH) begin
						mode_d = MODE_COMMENT;
					end else begin
						va = 1'b1;
						mode_d = MODE_IDLE;
						do_start = 1'b1;
					end
				end
				MODE_COMMENT: begin
					if (byte_s1 == CH_LF) mode_d = MODE_IDLE;
				end
				MODE_OP: begin
					mode_d = MODE_IDLE;
					va = 1'b1;
					if (pcls != CLS_END) begin
						item_a = make_tok(pcls, {48'd0, byte_s1, pend_q}, '0, 4'd2,
							trow_q, tcol_q);
					end else begin
						item_a = make_tok(CLS_CHAR, {56'd0, pend_q}, '0, 4'd1,
							trow_q, tcol_q);
						do_start = 1'b1;
					end
				end
				MODE_NUMBER, MODE_IDENT: begin
					if (append) begin
						buf_we = 1'b1;
						len_d = wlen;
						if (split) begin
							va = 1'b1;
							item_a = make_tok(wcls, word_lo, word_hi, wlen, trow_q, tcol_q);
							mode_d = MODE_IDLE;
							len_d = '0;
						end
					end else begin
						va = 1'b1;
						item_a = make_tok(wcls, word_lo, word_hi, wlen, trow_q, tcol_q);
						mode_d = MODE_IDLE;
						len_d = '0;
						do_start = 1'b1;
					end
				end
				default: begin
					mode_d = MODE_IDLE;
					do_start = 1'b1;
				end
			endcase

			if (do_start && !is_space(byte_s1)) begin
				trow_d = row_n;
				tcol_d = col_n;
				if (byte_s1 == CH_SLASH) begin
					mode_d = MODE_SLASH;
				end else if (is_op(byte_s1)) begin
					mode_d = MODE_OP;
					pend_d = byte_s1;
				end else if (is_digit(byte_s1) || is_alpha(byte_s1)) begin
					mode_d = is_digit(byte_s1) ? MODE_NUMBER : MODE_IDENT;
					buf_we = 1'b1;
					buf_widx = '0;
					len_d = 4'd1;
				end else begin
					vb = 1'b1;
					item_b = make_tok(CLS_CHAR, {56'd0, byte_s1}, '0, 4'd1, row_n, col_n);
				end
			end
		end

		if (vb) item_b.last_of_step = 1'b1;
		else item_a.last_of_step = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pend_q <= '0;
			len_q <= '0;
			row_q <= 16'd1;
			col_q <= '0;
			trow_q <= 16'd1;
			tcol_q <= '0;
		end else if (adv) begin
			mode_q <= mode_d;
			pend_q <= pend_d;
			len_q <= len_d;
			row_q <= row_d;
			col_q <= col_d;
			trow_q <= trow_d;
			tcol_q <= tcol_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && buf_we) buf_q[buf_widx] <= byte_s1;
	end

	// token queue
	assign pop = tokens.valid && tokens.ready;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (va) begin
				fifo_q[wr_q] <= item_a;
				if (vb) fifo_q[PTR_W'(wr_q + 1'b1)] <= item_b;
			end else if (vb) begin
				fifo_q[wr_q] <= item_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			logic [CNT_W-1:0] npush;
			npush = adv ? CNT_W'({1'b0, va} + {1'b0, vb}) : '0;
			wr_q <= PTR_W'(wr_q + npush);
			if (pop) rd_q <= PTR_W'(rd_q + 1'b1);
			cnt_q <= CNT_W'(cnt_q + npush - CNT_W'(pop));
		end
	end

	assign tokens.valid = (cnt_q != '0);
	assign tokens.token_class = fifo_q[rd_q].token_class;
	assign tokens.text_first_bytes = fifo_q[rd_q].text_first_bytes;
	assign tokens.text_next_bytes = fifo_q[rd_q].text_next_bytes;
	assign tokens.text_length = fifo_q[rd_q].text_length;
	assign tokens.start_row = fifo_q[rd_q].start_row;
	assign tokens.start_column = fifo_q[rd_q].start_column;
	assign tokens.last_of_step = fifo_q[rd_q].last_of_step;

`ifndef NO_ASSERTIONS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("token queue overfilled");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && (tokens.token_class == CLS_END) |-> tokens.last_of_step)
		else $error("end token not marked last");

	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && (tokens.text_length == 4'd0) |-> (tokens.token_class == CLS_END))
		else $error("empty text on a non-end token");

	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		adv && end_s1 |=> (row_q == 16'd1) && (col_q == '0) && (mode_q == MODE_IDLE))
		else $error("position not restarted after end of input");
`endif

endmodule

>>> bench/tb_top.sv
// testbench for the streaming tokenizer: byte stream in, predicted tokens checked out
`timescale 1ns / 100ps

module tb_top
	import slt_pkg::*;
();

	localparam int WORD_MAX = TOKEN_BUFFER_BYTES_DEF;

	typedef struct {
		logic [7:0] text_byte;
		logic       end_of_input;
	} src_item_t;

	logic clk;
	logic arst_n;

	slt_in_if  text_if ();
	slt_out_if token_if ();

	small_language_tokenizer_unit #(
		.TOKEN_BUFFER_BYTES(WORD_MAX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_if),
		.tokens(token_if)
	);

	src_item_t pending_bytes [$];
	tok_t      expected_tokens [$];
	tok_t      step_toks [$];

	int idle_pct;
	int stall_pct;
	int mismatch_count;
	int n_in;
	int n_out;
	int gen_count;

	// predictor state
	mode_t       scan_st;
	logic [7:0]  op_char;
	logic [7:0]  word_buf [16];
	logic [3:0]  word_len;
	logic [15:0] row_q;
	logic [15:0] col_q;
	logic [15:0] tok_row;
	logic [15:0] tok_col;

	string kw_names [9] = '{"if", "else", "while", "print", "scan", "int", "return",
		"break", "continue"};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit blank_char(logic [7:0] b);
		case (b)
			8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit digit_char(logic [7:0] b);
		return !(b < "0" || b > "9");
	endfunction

	function automatic bit letter_char(logic [7:0] b);
		return (b == "_") || !(b < "a" || b > "z") || !(b < "A" || b > "Z");
	endfunction

	function automatic bit op_lead(logic [7:0] b);
		case (b)
			CH_EQ, CH_LT, CH_GT, CH_BANG, CH_AMP, CH_BAR: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [4:0] pair_cls(logic [7:0] first, logic [7:0] b);
		case ({first, b})
			{CH_EQ, CH_EQ}: return CLS_EQ;
			{CH_LT, CH_EQ}: return CLS_LE;
			{CH_GT, CH_EQ}: return CLS_GE;
			{CH_BANG, CH_EQ}: return CLS_NE;
			{CH_AMP, CH_AMP}: return CLS_AND;
			{CH_BAR, CH_BAR}: return CLS_OR;
			default: return CLS_END;
		endcase
	endfunction

	function automatic void restart_text();
		scan_st = MODE_IDLE;
		op_char = '0;
		word_len = '0;
		row_q = 16'd1;
		col_q = '0;
		tok_row = 16'd1;
		tok_col = '0;
	endfunction

	function automatic void add_tok(logic [4:0] cls, logic [63:0] lo, logic [63:0] hi,
		logic [3:0] len, logic [15:0] row, logic [15:0] col);
		tok_t t;
		t.token_class = cls;
		t.text_first_bytes = lo;
		t.text_next_bytes = hi;
		t.text_length = len;
		t.start_row = row;
		t.start_column = col;
		t.last_of_step = 1'b0;
		if (step_toks.size() < 2) step_toks.push_back(t);
	endfunction

	function automatic void add_char(logic [7:0] b, logic [15:0] row, logic [15:0] col);
		add_tok(CLS_CHAR, {56'h0, b}, '0, 4'd1, row, col);
	endfunction

	function automatic logic [4:0] word_cls();
		logic [4:0] c;
		bit same;
		c = CLS_IDENT;
		if (scan_st == MODE_NUMBER) return CLS_NUMBER;
		for (int k = 0; k < 9; k++) begin
			if (kw_names[k].len() == int'(word_len)) begin
				same = 1'b1;
				for (int i = 0; i < int'(word_len); i++) begin
					if (kw_names[k][i] != word_buf[i]) same = 1'b0;
				end
				if (same && c == CLS_IDENT) c = 5'(CLS_KEYWORD0 + 5'(k));
			end
		end
		return c;
	endfunction

	function automatic void flush_word();
		logic [63:0] lo;
		logic [63:0] hi;
		lo = '0;
		hi = '0;
		for (int i = 0; i < 16; i++) begin
			if (i < int'(word_len)) begin
				if (i < 8) lo[8*i +: 8] = word_buf[i];
				else hi[8*(i-8) +: 8] = word_buf[i];
			end
		end
		add_tok(word_cls(), lo, hi, word_len, tok_row, tok_col);
		scan_st = MODE_IDLE;
		word_len = '0;
	endfunction

	function automatic void open_token(logic [7:0] b);
		if (blank_char(b)) return;
		tok_row = row_q;
		tok_col = col_q;
		if (b == CH_SLASH) begin
			scan_st = MODE_SLASH;
		end else if (op_lead(b)) begin
			scan_st = MODE_OP;
			op_char = b;
		end else if (digit_char(b) || letter_char(b)) begin
			scan_st = digit_char(b) ? MODE_NUMBER : MODE_IDENT;
			word_buf[0] = b;
			word_len = 4'd1;
		end else begin
			add_char(b, row_q, col_q);
		end
	endfunction

	task automatic scan_source_item(input logic [7:0] b, input logic eoi);
		logic [4:0] pcls;
		bit more;
		step_toks.delete();
		if (eoi) begin
			case (scan_st)
				MODE_SLASH: add_char(CH_SLASH, tok_row, tok_col);
				MODE_OP: add_char(op_char, tok_row, tok_col);
				MODE_NUMBER, MODE_IDENT: flush_word();
				default: ;
			endcase
			add_tok(CLS_END, '0, '0, 4'd0, row_q, col_q);
			restart_text();
		end else begin
			if (b == CH_LF) begin
				if (row_q != SAT16) row_q++;
				col_q = '0;
			end else if (col_q != SAT16) begin
				col_q++;
			end
			case (scan_st)
				MODE_SLASH: begin
					if (b == CH_SLASH) begin
						scan_st = MODE_COMMENT;
					end else begin
						add_char(CH_SLASH, tok_row, tok_col);
						scan_st = MODE_IDLE;
						open_token(b);
					end
				end
				MODE_COMMENT: begin
					if (b == CH_LF) scan_st = MODE_IDLE;
				end
				MODE_OP: begin
					pcls = pair_cls(op_char, b);
					scan_st = MODE_IDLE;
					if (pcls != CLS_END) begin
						add_tok(pcls, {48'h0, b, op_char}, '0, 4'd2, tok_row, tok_col);
					end else begin
						add_char(op_char, tok_row, tok_col);
						open_token(b);
					end
				end
				MODE_NUMBER, MODE_IDENT: begin
					more = (scan_st == MODE_NUMBER) ? digit_char(b)
						: (letter_char(b) || digit_char(b));
					if (more) begin
						word_buf[word_len] = b;
						word_len = word_len + 4'd1;
						if (word_len >= 4'(WORD_MAX - 1)) flush_word();
					end else begin
						flush_word();
						open_token(b);
					end
				end
				default: begin
					scan_st = MODE_IDLE;
					open_token(b);
				end
			endcase
		end
		if (step_toks.size() != 0) step_toks[step_toks.size() - 1].last_of_step = 1'b1;
		foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
	endtask

	task automatic report_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// source driver
	always @(posedge clk) begin : drive_text
		src_item_t nxt;
		if (!arst_n) begin
			text_if.valid <= 1'b0;
		end else if (!text_if.valid || text_if.ready) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
				nxt = pending_bytes.pop_front();
				text_if.valid <= 1'b1;
				text_if.text_byte <= nxt.text_byte;
				text_if.end_of_input <= nxt.end_of_input;
			end else begin
				text_if.valid <= 1'b0;
			end
		end
	end

	// token monitor
	always @(posedge clk) begin : watch_tokens
		tok_t want;
		tok_t got;
		if (!arst_n) begin
			token_if.ready <= 1'b0;
		end else begin
			if (text_if.valid && text_if.ready) begin
				scan_source_item(text_if.text_byte, text_if.end_of_input);
				n_in++;
			end
			if (token_if.valid && token_if.ready) begin
				got.token_class = token_if.token_class;
				got.text_first_bytes = token_if.text_first_bytes;
				got.text_next_bytes = token_if.text_next_bytes;
				got.text_length = token_if.text_length;
				got.start_row = token_if.start_row;
				got.start_column = token_if.start_column;
				got.last_of_step = token_if.last_of_step;
				n_out++;
				if (expected_tokens.size() == 0) begin
					$display("%0t unexpected token: class %0d text %h", $time,
						got.token_class, got.text_first_bytes);
					mismatch_count++;
				end else begin
					want = expected_tokens.pop_front();
					report_field("token_class", 64'(want.token_class), 64'(got.token_class));
					report_field("text_first_bytes", want.text_first_bytes,
						got.text_first_bytes);
					report_field("text_next_bytes", want.text_next_bytes,
						got.text_next_bytes);
					report_field("text_length", 64'(want.text_length), 64'(got.text_length));
					report_field("start_row", 64'(want.start_row), 64'(got.start_row));
					report_field("start_column", 64'(want.start_column),
						64'(got.start_column));
					report_field("last_of_step", 64'(want.last_of_step),
						64'(got.last_of_step));
				end
			end
			token_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic push_src(input logic [7:0] b, input bit eoi);
		src_item_t it;
		it.text_byte = b;
		it.end_of_input = eoi;
		pending_bytes.push_back(it);
		if (eoi || !blank_char(b)) gen_count++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_src(s[i], 1'b0);
	endtask

	function automatic logic [7:0] word_char(bit first);
		int r;
		r = $urandom_range(first ? 52 : 62);
		if (r < 26) return 8'("a" + r);
		if (r < 52) return 8'("A" + r - 26);
		if (r == 52) return "_";
		return 8'("0" + r - 53);
	endfunction

	function automatic logic [7:0] blank_pick();
		case ($urandom_range(5))
			0: return 8'h09;
			1: return 8'h0A;
			2: return 8'h0B;
			3: return 8'h0C;
			4: return 8'h0D;
			default: return 8'h20;
		endcase
	endfunction

	function automatic logic [7:0] op_pick();
		case ($urandom_range(5))
			0: return CH_EQ;
			1: return CH_LT;
			2: return CH_GT;
			3: return CH_BANG;
			4: return CH_AMP;
			default: return CH_BAR;
		endcase
	endfunction

	task automatic gen_fragment();
		int pick;
		int n;
		string kw;
		logic [7:0] b;
		pick = $urandom_range(99);
		if (pick < 18) begin
			n = ($urandom_range(4) == 0) ? $urandom_range(13, 32) : $urandom_range(1, 6);
			push_src(word_char(1'b1), 1'b0);
			for (int i = 1; i < n; i++) push_src(word_char(1'b0), 1'b0);
		end else if (pick < 32) begin
			kw = kw_names[$urandom_range(8)];
			case ($urandom_range(5))
				0: kw = kw.substr(0, kw.len() - 2);
				1: kw = {kw, "x"};
				default: ;
			endcase
			push_text(kw);
		end else if (pick < 44) begin
			n = ($urandom_range(4) == 0) ? $urandom_range(13, 32) : $urandom_range(1, 6);
			for (int i = 0; i < n; i++) push_src(8'("0" + $urandom_range(9)), 1'b0);
		end else if (pick < 56) begin
			case ($urandom_range(5))
				0: push_text("==");
				1: push_text("<=");
				2: push_text(">=");
				3: push_text("!=");
				4: push_text("&&");
				default: push_text("||");
			endcase
		end else if (pick < 64) begin
			push_src(op_pick(), 1'b0);
			push_src(($urandom_range(1) != 0) ? op_pick() : 8'($urandom_range(255)), 1'b0);
		end else if (pick < 70) begin
			push_src(CH_SLASH, 1'b0);
			push_src(8'($urandom_range(255)), 1'b0);
		end else if (pick < 78) begin
			push_text("//");
			n = $urandom_range(8);
			for (int i = 0; i < n; i++) begin
				b = 8'($urandom_range(255));
				if (b == CH_LF) b = "c";
				push_src(b, 1'b0);
			end
			if ($urandom_range(5) != 0) push_src(CH_LF, 1'b0);
		end else if (pick < 86) begin
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++) push_src(blank_pick(), 1'b0);
		end else if (pick < 96) begin
			push_src(8'($urandom_range(255)), 1'b0);
		end else begin
			push_src(8'($urandom_range(255)), 1'b1);
		end
		if ($urandom_range(1) == 0) push_src(blank_pick(), 1'b0);
	endtask

	task automatic drain_all();
		@(negedge clk);
		while (pending_bytes.size() != 0 || text_if.valid || expected_tokens.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic run_random_phase(input int idle, input int stall, input int n_items);
		idle_pct = idle;
		stall_pct = stall;
		gen_count = 0;
		while (gen_count < n_items) gen_fragment();
		drain_all();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		text_if.valid = 1'b0;
		text_if.text_byte = '0;
		text_if.end_of_input = 1'b0;
		token_if.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		mismatch_count = 0;
		n_in = 0;
		n_out = 0;
		gen_count = 0;
		restart_text();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: keyword, pair op, lone slash, lone op, extremes, comment, flushes at end
		push_text("if ==/a<=&|");
		push_src(8'h00, 1'b0);
		push_src(8'hFF, 1'b0);
		push_text("//z");
		push_src(CH_LF, 1'b0);
		push_text("7_");
		push_src(8'hA5, 1'b1);
		push_src(CH_GT, 1'b0);
		push_src(8'h5A, 1'b1);
		push_src(CH_SLASH, 1'b0);
		push_src(8'h00, 1'b1);
		push_text("//");
		push_src(8'hFF, 1'b1);
		drain_all();

		run_random_phase(0, 0, 250);
		run_random_phase(45, 0, 250);
		run_random_phase(0, 45, 250);
		run_random_phase(17, 17, 250);

		$display("covered %0d source transactions and %0d tokens", n_in, n_out);
		$display("phases: directed text, no idling, sender idle, receiver stall, both");
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout");
		$display("status: fail");
		$finish;
	end

endmodule
